/* design/bsc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, command and status codes, and helpers for the bounded stack calculator.
package bsc_pkg;

    localparam int CMD_W   = 3;
    localparam int PUSH_W  = 16;
    localparam int VAL_W   = 11;
    localparam int ST_W    = 3;
    localparam int DEPTH_W = 5;
    localparam int CAP_W   = 5;
    localparam int ARITH_W = 2 * VAL_W;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd9;

    localparam logic signed [ARITH_W-1:0] VAL_MAX = 22'sd999;
    localparam logic signed [ARITH_W-1:0] VAL_MIN = -22'sd999;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHOW  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_DIGITS = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
    localparam logic [ST_W-1:0] ST_BOUNDS = 3'd3;
    localparam logic [ST_W-1:0] ST_FEW    = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd5;

    // Movement of the stack cells for one command.
    typedef struct packed {
        logic push;  // every cell but cell 0 takes the value of the cell above it
        logic pop;   // every cell but cell 0 and the deepest takes the value of the cell below it
    } cell_ctrl_t;

    function automatic logic in_range(input logic signed [ARITH_W-1:0] v);
        in_range = (v >= VAL_MIN) && (v <= VAL_MAX);
    endfunction

endpackage

/* design/bounded_stack_calculator_core.sv */
`timescale 1ns / 1ps
// Bounded stack calculator: commands in, one status beat out per command.
//
// The input channel carries one command per beat: s_tuser holds the command
// code and s_tdata the signed value for a push. The output channel returns
// one beat per command with the status code on m_tuser and the displayed
// value and resulting stack depth on m_tdata.
// The stack is a row of cells; the top entry sits in cell 0. A push moves
// every entry one cell down, and an arithmetic command writes its result
// into cell 0 while every deeper entry moves one cell up, so the two
// operands are always read from fixed registers.
// Each command is decoded and executed in the cycle its beat is accepted,
// and the result beat appears on the next cycle. Throughput is one command
// per cycle while the receiver takes each beat, limited by the single output register.
// When the receiver stalls the result beat is held; the input is still
// taken in that cycle if the held beat is taken at the same edge.
// Reset empties the stack, drops any pending result beat and sets the
// capacity register to 9. It is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while no command is in flight (not enforced).
module bounded_stack_calculator_core
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,  // capacity
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,      // [15:0] push_value
    input  logic [2:0]        s_tuser,      // [2:0] cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,      // [10:0] shown_value, [15:11] depth
    output logic [2:0]        m_tuser       // [2:0] status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic [2:0]       m_tuser_reg;

    logic             accept;
    cell_ctrl_t       dec_ctrl;
    cell_ctrl_t       cell_ctrl;
    logic [VAL_W-1:0] alu_result;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] shown_value;
    logic [VAL_W-1:0] cell_val [STACK_DEPTH];
    logic [EXT_W-1:0] depth_ext;

    // A new command is taken whenever the output register is free or is
    // being emptied at this edge.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bsc_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .cmd         (s_tuser),
        .push_value  (s_tdata),
        .top_val     (cell_val[0]),
        .next_val    (cell_val[1]),
        .capacity    (cap_reg),
        .count       (count_reg),
        .count_next  (count_next),
        .ctrl        (dec_ctrl),
        .result      (alu_result),
        .status      (status),
        .shown_value (shown_value)
    );

    // The cells move only for an accepted command.
    assign cell_ctrl.push = dec_ctrl.push && accept;
    assign cell_ctrl.pop  = dec_ctrl.pop && accept;

    // Cell 0 takes the pushed value from above and the arithmetic result
    // from below; the deepest cell has nothing below it and keeps its value.
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [VAL_W-1:0] above_val;
            logic [VAL_W-1:0] below_val;

            if (gi == 0) begin : g_top
                assign above_val = s_tdata[VAL_W-1:0];
                assign below_val = alu_result;
            end else if (gi == STACK_DEPTH - 1) begin : g_bottom
                assign above_val = cell_val[gi-1];
                assign below_val = cell_val[gi];
            end else begin : g_mid
                assign above_val = cell_val[gi-1];
                assign below_val = cell_val[gi+1];
            end

            bsc_cell u_cell (
                .aclk    (aclk),
                .ctrl    (cell_ctrl),
                .above_i (above_val),
                .below_i (below_val),
                .val_o   (cell_val[gi])
            );
        end
    endgenerate

    assign depth_ext = EXT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Output register: loaded on every accepted command, held while stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {depth_ext[DEPTH_W-1:0], shown_value};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* design/bsc_cell.sv */
`timescale 1ns / 1ps
// One stack cell: holds one entry and moves it toward its upper or lower neighbor.
module bsc_cell
    import bsc_pkg::*;
(
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [VAL_W-1:0] above_i,
    input  logic [VAL_W-1:0] below_i,
    output logic [VAL_W-1:0] val_o
);

    logic [VAL_W-1:0] val_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            val_reg <= above_i;
        end else if (ctrl.pop) begin
            val_reg <= below_i;
        end
    end

    assign val_o = val_reg;

endmodule

/* design/bsc_ctrl.sv */
`timescale 1ns / 1ps
// Command decoder and arithmetic unit working on the two top cells.
module bsc_ctrl
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic [CMD_W-1:0]       cmd,
    input  logic [PUSH_W-1:0]      push_value,
    input  logic [VAL_W-1:0]       top_val,
    input  logic [VAL_W-1:0]       next_val,
    input  logic [CAP_W-1:0]       capacity,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] count,
    output logic [$clog2(STACK_DEPTH+1)-1:0] count_next,
    output cell_ctrl_t             ctrl,
    output logic [VAL_W-1:0]       result,
    output logic [ST_W-1:0]        status,
    output logic [VAL_W-1:0]       shown_value
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [LIM_W-1:0]          cnt_ext;
    logic [LIM_W-1:0]          cap_ext;
    logic [LIM_W-1:0]          limit;
    logic signed [ARITH_W-1:0] op1;
    logic signed [ARITH_W-1:0] op2;
    logic signed [ARITH_W-1:0] push_ext;
    logic signed [ARITH_W-1:0] arith;

    assign cnt_ext  = LIM_W'(count);
    assign cap_ext  = LIM_W'(capacity);
    assign limit    = (cap_ext < LIM_W'(STACK_DEPTH)) ? cap_ext : LIM_W'(STACK_DEPTH);
    assign op1      = ARITH_W'($signed(top_val));
    assign op2      = ARITH_W'($signed(next_val));
    assign push_ext = ARITH_W'($signed(push_value));

    always_comb begin
        case (cmd)
            CMD_ADD: arith = op1 + op2;
            CMD_SUB: arith = op1 - op2;
            default: arith = op1 * op2;
        endcase
    end

    assign result = arith[VAL_W-1:0];

    always_comb begin
        status      = ST_OK;
        shown_value = '0;
        ctrl        = '0;
        count_next  = count;
        unique case (cmd) inside
            CMD_PUSH: begin
                if (!in_range(push_ext)) begin
                    status = ST_DIGITS;
                end else if (cnt_ext >= limit) begin
                    status = ST_FULL;
                end else begin
                    ctrl.push  = 1'b1;
                    count_next = count + CNT_W'(1);
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                if (cnt_ext < LIM_W'(2)) begin
                    status = ST_FEW;
                end else if (!in_range(arith)) begin
                    status = ST_BOUNDS;
                end else begin
                    ctrl.pop   = 1'b1;
                    count_next = count - CNT_W'(1);
                end
            end
            CMD_SHOW: begin
                if (count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    shown_value = top_val;
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

endmodule

/* design/bsc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the bounded stack calculator and its bind.
module bsc_checker
    import bsc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A held result beat stays unchanged until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // With no pending result the block must take a command.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A shown value is nonzero only for a successful display.
    a_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[10:0] != 11'd0) |-> m_tuser == ST_OK)
        else $error("shown value on a failed command");

    // An empty display reports an empty stack.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[15:11] == 5'd0)
        else $error("empty display with entries on the stack");

    // Too few operands means the depth is below two.
    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FEW) |-> m_tdata[15:11] < 5'd2)
        else $error("too few operands reported with two or more entries");

endmodule

bind bounded_stack_calculator_core bsc_checker u_bsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/bounded_stack_calculator_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bounded stack calculator core: scoreboard with predictor, drivers, top.

import bsc_pkg::*;

// Command codes that the block treats as no operation.
localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] shown;
    logic [DEPTH_W-1:0]      depth;
} calc_reply_t;

// Predicts the reply of every accepted command and checks the replies that come back.
class stack_reply_board;
    localparam int CELLS     = 16;
    localparam int VAL_LIMIT = 999;

    logic signed [VAL_W-1:0] cells [CELLS];
    int                      level;
    int                      capacity;
    calc_reply_t             expected_replies[$];
    int                      mismatches;

    function new();
        level      = 0;
        capacity   = int'(CAP_RESET);
        mismatches = 0;
        foreach (cells[i]) cells[i] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
        capacity = int'(value);
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction

    function void predict_command(logic [CMD_W-1:0] cmd, logic signed [PUSH_W-1:0] value);
        calc_reply_t r;
        int          operand;
        int          lim;
        int          top;
        int          nxt;
        int          res;
        operand  = value;
        r.status = ST_OK;
        r.shown  = '0;
        lim      = (capacity < CELLS) ? capacity : CELLS;
        case (cmd)
            CMD_PUSH: begin
                if (operand < -VAL_LIMIT || operand > VAL_LIMIT) begin
                    r.status = ST_DIGITS;
                end else if (level >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    cells[level] = operand[VAL_W-1:0];
                    level++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                if (level < 2) begin
                    r.status = ST_FEW;
                end else begin
                    top = cells[level-1];
                    nxt = cells[level-2];
                    if (cmd == CMD_ADD) res = top + nxt;
                    else if (cmd == CMD_SUB) res = top - nxt;
                    else res = top * nxt;
                    if (res < -VAL_LIMIT || res > VAL_LIMIT) begin
                        r.status = ST_BOUNDS;
                    end else begin
                        cells[level-2] = res[VAL_W-1:0];
                        level--;
                    end
                end
            end
            CMD_SHOW: begin
                if (level == 0) r.status = ST_EMPTY;
                else r.shown = cells[level-1];
            end
            CMD_CLEAR: begin
                level = 0;
            end
            default: begin
            end
        endcase
        r.depth = level[DEPTH_W-1:0];
        expected_replies.push_back(r);
    endfunction

    task report_mismatch(string field, int got, int want);
        if (mismatches < 100)
            $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    task check_reply(logic [ST_W-1:0] status, logic [VAL_W-1:0] shown,
                     logic [DEPTH_W-1:0] depth);
        calc_reply_t want;
        if (expected_replies.size() == 0) begin
            report_mismatch("reply with no command pending", int'(status), 0);
        end else begin
            want = expected_replies.pop_front();
            if (status !== want.status)
                report_mismatch("status", int'(status), int'(want.status));
            if (shown !== want.shown)
                report_mismatch("shown value", int'($signed(shown)), int'(want.shown));
            if (depth !== want.depth)
                report_mismatch("depth", int'(depth), int'(want.depth));
        end
    endtask
endclass

module bounded_stack_calculator_core_tb;

    localparam int STACK_CELLS   = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 148;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CAP_W-1:0]   cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;   // [15:0] push_value
    logic [2:0]         s_tuser;   // [2:0] cmd
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;   // [10:0] shown_value, [15:11] depth
    logic [2:0]         m_tuser;   // [2:0] status

    stack_reply_board   board;

    // Idle bounds for the current phase, and the request for one long receiver stall.
    int                 send_gap_max;
    int                 recv_gap_max;
    bit                 stall_request;
    bit                 stall_done;

    bounded_stack_calculator_core #(
        .STACK_DEPTH(STACK_CELLS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offer one command beat after a random gap and wait until it is taken.
    // Valid stays high afterwards; the next call or end_of_commands decides.
    task send_cmd(input logic [CMD_W-1:0] cmd, input int value);
        int gap;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value[15:0];
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        board.predict_command(cmd, value[15:0]);
    endtask

    task end_of_commands();
        s_tvalid <= 1'b0;
    endtask

    // Wait until every reply is back, then let the pipeline settle.
    task wait_for_replies();
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_capacity(input logic [CAP_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_capacity(value);
    endtask

    // Mostly well-formed sequences: small pushes keep products in range so that
    // arithmetic succeeds often, with boundary values and raw noise mixed in.
    task random_command(output logic [CMD_W-1:0] cmd, output int value);
        int pick;
        int vpick;
        pick  = $urandom_range(0, 99);
        value = int'($urandom_range(0, 65535));
        if (pick < 45) begin
            cmd   = CMD_PUSH;
            vpick = $urandom_range(0, 99);
            if (vpick < 60) value = int'($urandom_range(0, 60)) - 30;
            else if (vpick < 80) value = int'($urandom_range(0, 1998)) - 999;
            else if (vpick < 88) begin
                case ($urandom_range(0, 3))
                    0: value = 999;
                    1: value = -999;
                    2: value = 1000;
                    default: value = -1000;
                endcase
            end
        end else if (pick < 60) cmd = CMD_ADD;
        else if (pick < 70) cmd = CMD_SUB;
        else if (pick < 80) cmd = CMD_MUL;
        else if (pick < 90) cmd = CMD_SHOW;
        else if (pick < 93) cmd = CMD_CLEAR;
        else if (pick < 97) cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
        else cmd = CMD_W'($urandom_range(0, 7));
    endtask

    // Receiver: random ready gaps per beat, one long stall on request.
    // It starts only once reset has been released.
    initial begin
        int gap;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (stall_request && !stall_done) begin
                stall_done = 1'b1;
                gap = STALL_CYCLES;
            end else begin
                gap = (recv_gap_max == 0) ? 0 : $urandom_range(0, recv_gap_max);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            board.check_reply(m_tuser, m_tdata[10:0], m_tdata[15:11]);
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [CMD_W-1:0] cmd;
        int               value;
        int               caps [PHASE_COUNT];
        board         = new();
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        send_gap_max  = 16;
        recv_gap_max  = 16;
        stall_request = 1'b0;
        stall_done    = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks under the reset capacity: empty stack, refused
        // values at both ends, overflow of sums and products, and no-ops.
        send_cmd(CMD_SHOW, 0);
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_PUSH, 1000);
        send_cmd(CMD_PUSH, -1000);
        send_cmd(CMD_PUSH, 32767);
        send_cmd(CMD_PUSH, -32768);
        send_cmd(CMD_PUSH, 999);
        send_cmd(CMD_MUL, 0);
        send_cmd(CMD_PUSH, 999);
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_MUL, 0);
        send_cmd(CMD_SUB, 0);
        send_cmd(CMD_PUSH, -999);
        send_cmd(CMD_SUB, 0);
        send_cmd(CMD_PUSH, -1);
        send_cmd(CMD_MUL, 0);
        send_cmd(CMD_SHOW, 0);
        send_cmd(CMD_SPARE_A, 16'hffff);
        send_cmd(CMD_SPARE_B, 0);
        end_of_commands();
        wait_for_replies();

        // Capacity one, with an entry left over from above: push is full.
        write_capacity(5'd1);
        send_cmd(CMD_PUSH, 3);
        send_cmd(CMD_CLEAR, 0);
        send_cmd(CMD_PUSH, 4);
        send_cmd(CMD_PUSH, 5);
        end_of_commands();
        wait_for_replies();

        // Capacity zero refuses every push.
        write_capacity(5'd0);
        send_cmd(CMD_CLEAR, 0);
        send_cmd(CMD_PUSH, 0);
        end_of_commands();
        wait_for_replies();

        caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd12, 5'd9, 5'd3};
        caps[PHASE_COUNT-1] = $urandom_range(0, 31);
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(caps[p][CAP_W-1:0]);
            send_gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 16 : 4);
            recv_gap_max = (p % 4 == 0) ? 0 : ((p % 4 == 1) ? 16 : ((p % 4 == 2) ? 2 : 8));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Early in a phase without sender gaps, the receiver
                // stalls long enough for the block to back up its input.
                if (p == 3 && i == 20) stall_request = 1'b1;
                random_command(cmd, value);
                send_cmd(cmd, value);
            end
            end_of_commands();
            wait_for_replies();
        end

        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
